// ----- rtl/sdspi_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdspi_pkg : shared types and constants
// Sequencer state, configuration and result records, phase, command and
// status codes for the SD card SPI-mode init sequencer.
// ---------------------------------------------------------------------------
package sdspi_pkg;

    localparam logic [4:0] PH_IDLE  = 5'd0;
    localparam logic [4:0] PH_WAKE  = 5'd1;
    localparam logic [4:0] PH_SEND  = 5'd2;
    localparam logic [4:0] PH_POLL  = 5'd3;
    localparam logic [4:0] PH_R7    = 5'd4;
    localparam logic [4:0] PH_FLUSH = 5'd5;
    localparam logic [4:0] PH_DONE0 = 5'd8;

    localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
    localparam logic [5:0] CMD_SEND_OP  = 6'd1;
    localparam logic [5:0] CMD_SEND_IF  = 6'd8;
    localparam logic [5:0] CMD_SET_BLEN = 6'd16;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_CMD0_BAD = 3'd1;
    localparam logic [2:0] ST_CMD8_BAD = 3'd2;
    localparam logic [2:0] ST_OCR_BAD  = 3'd3;
    localparam logic [2:0] ST_BLEN_BAD = 3'd4;
    localparam logic [2:0] ST_BUSY_TMO = 3'd5;

    localparam logic [1:0] REG_POLL_LIMIT  = 2'd0;
    localparam logic [1:0] REG_RETRY_LIMIT = 2'd1;
    localparam logic [1:0] REG_BLOCK_LEN   = 2'd2;

    localparam logic [0:0] KIND_START = 1'b0;

    localparam logic [7:0]  BYTE_IDLE   = 8'hFF;
    localparam logic [7:0]  CMD_START   = 8'h40;
    localparam logic [7:0]  CRC_CMD0    = 8'h95;
    localparam logic [7:0]  CRC_CMD8    = 8'h87;
    localparam logic [7:0]  R1_IDLE     = 8'h01;
    localparam logic [7:0]  R1_READY    = 8'h00;
    localparam logic [7:0]  R1_ILLEGAL  = 8'h05;
    localparam logic [31:0] IF_COND_ARG = 32'h0000_01AA;
    localparam logic [11:0] IF_ECHO     = 12'h1AA;
    localparam logic [15:0] RETRY_MAX   = 16'hFFFF;

    typedef struct packed {
        logic [4:0]  phase;
        logic [3:0]  byte_count;
        logic [7:0]  poll_count;
        logic [15:0] retry_count;
        logic [5:0]  cur_cmd;
        logic [7:0]  response;
        logic [11:0] echo;       // only the low 12 bits of R7 are checked
    } seq_state_t;

    typedef struct packed {
        logic [7:0]  poll_limit;
        logic [15:0] retry_limit;
        logic [12:0] block_length;
    } seq_cfg_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       chip_select_high;
        logic       done_res;
        logic [2:0] status;
        logic [7:0] last_response;
    } seq_result_t;

endpackage

// ----- rtl/sdspi_step.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdspi_step : next-state and result logic
// Advances the init sequence by one item and forms the byte to send next.
// ---------------------------------------------------------------------------
module sdspi_step #(
    parameter int WAKE_BYTES = 10
) (
    input  sdspi_pkg::seq_state_t  cur,
    input  sdspi_pkg::seq_cfg_t    cfg,
    input  logic                   kind,
    input  logic [7:0]             rx_byte,
    output sdspi_pkg::seq_state_t  nxt,
    output sdspi_pkg::seq_result_t res
);

    logic [15:0] retry_inc;
    logic [31:0] arg;
    logic [7:0]  frame;

    assign retry_inc = (cur.retry_count < sdspi_pkg::RETRY_MAX)
                     ? cur.retry_count + 16'd1 : cur.retry_count;

    always_comb
    begin
        nxt = cur;
        if (kind == sdspi_pkg::KIND_START)
        begin
            nxt.phase       = sdspi_pkg::PH_WAKE;
            nxt.byte_count  = 4'd0;
            nxt.poll_count  = 8'd0;
            nxt.retry_count = 16'd0;
            nxt.cur_cmd     = sdspi_pkg::CMD_GO_IDLE;
            nxt.response    = sdspi_pkg::BYTE_IDLE;
            nxt.echo        = 12'd0;
        end
        else
        begin
            case (cur.phase)
                sdspi_pkg::PH_WAKE:
                begin
                    if (cur.poll_count < 8'(WAKE_BYTES))
                        nxt.poll_count = cur.poll_count + 8'd1;
                    else
                    begin
                        nxt.cur_cmd    = sdspi_pkg::CMD_GO_IDLE;
                        nxt.byte_count = 4'd0;
                        nxt.phase      = sdspi_pkg::PH_SEND;
                    end
                end
                sdspi_pkg::PH_SEND:
                begin
                    if (cur.byte_count < 4'd5)
                        nxt.byte_count = cur.byte_count + 4'd1;
                    else
                    begin
                        nxt.phase      = sdspi_pkg::PH_POLL;
                        nxt.poll_count = 8'd0;
                    end
                end
                sdspi_pkg::PH_POLL:
                begin
                    if (rx_byte == sdspi_pkg::BYTE_IDLE && cur.poll_count < cfg.poll_limit)
                        nxt.poll_count = cur.poll_count + 8'd1;
                    else
                    begin
                        nxt.response = rx_byte;
                        if (cur.cur_cmd == sdspi_pkg::CMD_SEND_IF
                            && rx_byte == sdspi_pkg::R1_IDLE)
                        begin
                            nxt.phase      = sdspi_pkg::PH_R7;
                            nxt.byte_count = 4'd0;
                            nxt.echo       = 12'd0;
                        end
                        else
                            nxt.phase = sdspi_pkg::PH_FLUSH;
                    end
                end
                sdspi_pkg::PH_R7:
                begin
                    nxt.echo = {cur.echo[3:0], rx_byte};
                    if (cur.byte_count < 4'd3)
                        nxt.byte_count = cur.byte_count + 4'd1;
                    else
                        nxt.phase = sdspi_pkg::PH_FLUSH;
                end
                sdspi_pkg::PH_FLUSH:
                begin
                    if (rx_byte == sdspi_pkg::BYTE_IDLE)
                    begin
                        // response decision, then either next command or finish
                        nxt.byte_count = 4'd0;
                        case (cur.cur_cmd)
                            sdspi_pkg::CMD_GO_IDLE:
                            begin
                                if (cur.response != sdspi_pkg::R1_IDLE)
                                    nxt.phase = sdspi_pkg::PH_DONE0
                                              + 5'(sdspi_pkg::ST_CMD0_BAD);
                                else
                                begin
                                    nxt.cur_cmd = sdspi_pkg::CMD_SEND_IF;
                                    nxt.phase   = sdspi_pkg::PH_SEND;
                                end
                            end
                            sdspi_pkg::CMD_SEND_IF:
                            begin
                                if (cur.response == sdspi_pkg::R1_ILLEGAL)
                                begin
                                    nxt.cur_cmd = sdspi_pkg::CMD_SEND_OP;
                                    nxt.phase   = sdspi_pkg::PH_SEND;
                                end
                                else if (cur.response != sdspi_pkg::R1_IDLE)
                                    nxt.phase = sdspi_pkg::PH_DONE0
                                              + 5'(sdspi_pkg::ST_CMD8_BAD);
                                else if (cur.echo != sdspi_pkg::IF_ECHO)
                                    nxt.phase = sdspi_pkg::PH_DONE0
                                              + 5'(sdspi_pkg::ST_OCR_BAD);
                                else
                                begin
                                    nxt.cur_cmd = sdspi_pkg::CMD_SEND_OP;
                                    nxt.phase   = sdspi_pkg::PH_SEND;
                                end
                            end
                            sdspi_pkg::CMD_SEND_OP:
                            begin
                                nxt.retry_count = retry_inc;
                                if (cur.response == sdspi_pkg::R1_READY)
                                begin
                                    nxt.cur_cmd = sdspi_pkg::CMD_SET_BLEN;
                                    nxt.phase   = sdspi_pkg::PH_SEND;
                                end
                                else if (cfg.retry_limit != 16'd0
                                         && retry_inc >= cfg.retry_limit)
                                    nxt.phase = sdspi_pkg::PH_DONE0
                                              + 5'(sdspi_pkg::ST_BUSY_TMO);
                                else
                                begin
                                    nxt.cur_cmd = sdspi_pkg::CMD_SEND_OP;
                                    nxt.phase   = sdspi_pkg::PH_SEND;
                                end
                            end
                            default:
                            begin
                                if (cur.response == sdspi_pkg::R1_READY)
                                    nxt.phase = sdspi_pkg::PH_DONE0
                                              + 5'(sdspi_pkg::ST_OK);
                                else
                                    nxt.phase = sdspi_pkg::PH_DONE0
                                              + 5'(sdspi_pkg::ST_BLEN_BAD);
                            end
                        endcase
                    end
                end
                default:
                begin
                    // idle or finished: exchange items change nothing
                end
            endcase
        end
    end

    // command frame byte taken from the updated state
    always_comb
    begin
        case (nxt.cur_cmd)
            sdspi_pkg::CMD_SEND_IF:  arg = sdspi_pkg::IF_COND_ARG;
            sdspi_pkg::CMD_SET_BLEN: arg = {19'd0, cfg.block_length};
            default:                 arg = 32'd0;
        endcase
        case (nxt.byte_count)
            4'd0: frame = sdspi_pkg::CMD_START | {2'b00, nxt.cur_cmd};
            4'd1: frame = arg[31:24];
            4'd2: frame = arg[23:16];
            4'd3: frame = arg[15:8];
            4'd4: frame = arg[7:0];
            default:
            begin
                if (nxt.cur_cmd == sdspi_pkg::CMD_GO_IDLE)
                    frame = sdspi_pkg::CRC_CMD0;
                else if (nxt.cur_cmd == sdspi_pkg::CMD_SEND_IF)
                    frame = sdspi_pkg::CRC_CMD8;
                else
                    frame = sdspi_pkg::BYTE_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.tx_byte          = sdspi_pkg::BYTE_IDLE;
        res.chip_select_high = 1'b0;
        res.done_res         = 1'b0;
        res.status           = sdspi_pkg::ST_OK;
        res.last_response    = nxt.response;
        if (nxt.phase == sdspi_pkg::PH_IDLE || nxt.phase == sdspi_pkg::PH_WAKE)
            res.chip_select_high = 1'b1;
        else if (nxt.phase == sdspi_pkg::PH_SEND)
            res.tx_byte = frame;
        else if (nxt.phase >= sdspi_pkg::PH_DONE0)
        begin
            res.done_res = 1'b1;
            res.status   = 3'(nxt.phase - sdspi_pkg::PH_DONE0);
        end
    end

endmodule

// ----- rtl/sd_spi_init_sequencer.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sd_spi_init_sequencer : SD card SPI-mode initialisation master
// Wake clocks, CMD0, CMD8 (+R7 check), CMD1 polling and CMD16; reports the
// next MOSI byte, chip select, done, status and last R1 for each item.
// ---------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  in       | in_valid / in_ready    | kind, rx_byte
//  out      | out_valid / out_ready  | tx_byte, chip_select_high, done_res,
//           |                        | status, last_response
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  One item per cycle while out_ready holds; out_valid rises once an accepted
//  item has passed the item register, the step logic and the result register.
//  Sequencer state updates when an item moves from the item register into
//  the result register, so a stalled output holds the item register too.
//  Reset returns sequencer state, cfg and valid flags to power-on values (item
//  and result payloads are not reset); cfg is always ready.
// ---------------------------------------------------------------------------
module sd_spi_init_sequencer #(
    parameter int WAKE_BYTES = 10
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  rx_byte,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  tx_byte,
    output logic        chip_select_high,
    output logic        done_res,
    output logic [2:0]  status,
    output logic [7:0]  last_response,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    sdspi_pkg::seq_cfg_t    cfg_reg;
    sdspi_pkg::seq_state_t  state_reg;
    sdspi_pkg::seq_state_t  state_next;
    sdspi_pkg::seq_result_t res_reg;
    sdspi_pkg::seq_result_t res_next;

    logic       item_valid_reg;
    logic       item_kind_reg;
    logic [7:0] item_rx_reg;
    logic       out_valid_reg;
    logic       advance;

    assign cfg_ready = 1'b1;
    assign advance   = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poll_limit   <= 8'd9;
            cfg_reg.retry_limit  <= 16'd0;
            cfg_reg.block_length <= 13'd512;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sdspi_pkg::REG_POLL_LIMIT:  cfg_reg.poll_limit   <= cfg_data[7:0];
                sdspi_pkg::REG_RETRY_LIMIT: cfg_reg.retry_limit  <= cfg_data;
                sdspi_pkg::REG_BLOCK_LEN:   cfg_reg.block_length <= cfg_data[12:0];
                default:
                begin
                end
            endcase
        end
    end

    // item register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_kind_reg <= kind;
            item_rx_reg   <= rx_byte;
        end
    end

    sdspi_step #(
        .WAKE_BYTES (WAKE_BYTES)
    ) u_step (
        .cur     (state_reg),
        .cfg     (cfg_reg),
        .kind    (item_kind_reg),
        .rx_byte (item_rx_reg),
        .nxt     (state_next),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase       <= sdspi_pkg::PH_IDLE;
            state_reg.byte_count  <= 4'd0;
            state_reg.poll_count  <= 8'd0;
            state_reg.retry_count <= 16'd0;
            state_reg.cur_cmd     <= sdspi_pkg::CMD_GO_IDLE;
            state_reg.response    <= sdspi_pkg::BYTE_IDLE;
            state_reg.echo        <= 12'd0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            if (advance)
                state_reg <= state_next;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid        = out_valid_reg;
    assign tx_byte          = res_reg.tx_byte;
    assign chip_select_high = res_reg.chip_select_high;
    assign done_res         = res_reg.done_res;
    assign status           = res_reg.status;
    assign last_response    = res_reg.last_response;

    // start item always lands in the wake phase
    a_start_wake: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item_kind_reg == sdspi_pkg::KIND_START
        |=> state_reg.phase == sdspi_pkg::PH_WAKE)
        else $error("start item did not enter wake phase");

    // command frames are six bytes
    a_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == sdspi_pkg::PH_SEND |-> state_reg.byte_count <= 4'd5)
        else $error("frame byte count out of range");

    // finished sequence keeps the card selected
    a_done_cs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !chip_select_high && tx_byte == sdspi_pkg::BYTE_IDLE)
        else $error("done result with card deselected or non-idle byte");

    // status only carries a code once finished
    a_status_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !done_res |-> status == sdspi_pkg::ST_OK)
        else $error("non-zero status while running");

endmodule
